// File: hw/rtl/gis_pkg.sv
package gis_pkg;

    // largest graph the search handles
    localparam int MAX_VERTICES = 8;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    // item kinds carried on s_tuser
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;

    // one adjacency row, bit j set for an edge to vertex j
    typedef logic [MAX_VERTICES-1:0] row_t;

    // vertex mapping, one image per vertex of graph a
    typedef logic [MAX_VERTICES-1:0][IDX_W-1:0] perm_t;

    // result of one lexicographic step
    typedef struct packed {
        perm_t next;
        logic  wrap;
    } perm_step_t;

endpackage

// File: hw/rtl/gis_row_mem.sv
module gis_row_mem (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [gis_pkg::IDX_W-1:0] wr_addr,
    input  gis_pkg::row_t            wr_data,
    input  logic                     rd_en,
    input  logic [gis_pkg::IDX_W-1:0] rd_addr,
    output gis_pkg::row_t            rd_data
);
    import gis_pkg::*;

    row_t                    mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_reg;
    row_t                    rd_data_reg;
    logic                    rd_valid_reg;

    // per-row valid bits, a row never written reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // row storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/gis_perm_step.sv
module gis_perm_step (
    input  logic [gis_pkg::CNT_W-1:0] count,
    input  gis_pkg::perm_t            perm,
    output gis_pkg::perm_step_t       step
);
    import gis_pkg::*;

    logic             have_piv;
    logic [IDX_W-1:0] piv;
    logic [IDX_W-1:0] succ;
    logic [CNT_W-1:0] src_w [MAX_VERTICES];

    // pivot: last position whose entry is below its right neighbor
    always_comb begin
        have_piv = 1'b0;
        piv      = '0;
        for (int k = 1; k < MAX_VERTICES; k++) begin
            if ((CNT_W'(k) < count) && (perm[k-1] < perm[k])) begin
                have_piv = 1'b1;
                piv      = IDX_W'(k - 1);
            end
        end
    end

    // successor: last position holding a value above the pivot value
    always_comb begin
        succ = '0;
        for (int k = 0; k < MAX_VERTICES; k++) begin
            if ((CNT_W'(k) < count) && (perm[k] > perm[piv])) begin
                succ = IDX_W'(k);
            end
        end
    end

    // swap pivot and successor, then reverse the tail behind the pivot
    always_comb begin
        step.wrap = !have_piv;
        for (int k = 0; k < MAX_VERTICES; k++) begin
            src_w[k] = count + CNT_W'(piv) - CNT_W'(k);
            if (CNT_W'(k) >= count) begin
                step.next[k] = perm[k];
            end else if (!have_piv) begin
                // last ordering wraps back to the identity
                step.next[k] = IDX_W'(k);
            end else if (IDX_W'(k) < piv) begin
                step.next[k] = perm[k];
            end else if (IDX_W'(k) == piv) begin
                step.next[k] = perm[succ];
            end else if (src_w[k][IDX_W-1:0] == succ) begin
                step.next[k] = perm[piv];
            end else begin
                step.next[k] = perm[src_w[k][IDX_W-1:0]];
            end
        end
    end

endmodule

// File: hw/rtl/graph_isomorphism_search_unit.sv
// Brute-force isomorphism search between two graphs of up to eight vertices.
// Input stream: s_tuser selects load row of graph a, load row of graph b or
// run; a load writes one adjacency row and sets that graph's vertex count.
// Result stream: one transfer per vertex (vertex, image, found) with m_tlast
// on the final one, or a single transfer with m_tlast set: not found, or
// found for two empty graphs. Loads are taken even while a result is waiting.
// A run walks vertex orderings in lexicographic order. Each ordering is
// checked row by row through the two row memories: one read per row, the
// compare in the next cycle, and a mismatch moves to the next ordering at
// once. A match sets up the output register and then gives one result per
// cycle while m_tready is high. Unequal counts or empty graphs skip the
// search and go straight to the output. s_tready is low for the whole run.
// Reset clears both counts and marks every adjacency row as zero.
// A stalled receiver holds the output register; the search itself waits
// only when it has a result to place.
module graph_isomorphism_search_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row_index[2:0], row_bits[10:3], vertex_count[14:11], zero pad [15]
    input  logic [gis_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found[0], vertex[3:1], image[6:4], zero pad [7]
    output logic [gis_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import gis_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_a_reg, count_a_next;
    logic [CNT_W-1:0]      count_b_reg, count_b_next;
    perm_t                 perm_reg, perm_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  emit_single_reg, emit_single_next;
    logic                  emit_found_reg, emit_found_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic [1:0]       in_kind;
    logic [IDX_W-1:0] in_row;
    row_t             in_bits;
    logic [CNT_W-1:0] in_cnt;
    logic [CNT_W-1:0] in_cnt_sat;
    logic             in_xfer;
    logic             wr_a;
    logic             wr_b;
    logic             rd_issue;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    row_t             row_a;
    row_t             row_b;
    logic             row_ok;
    logic             out_free;
    logic [CNT_W-1:0] last_idx;
    perm_t            perm_ident;
    perm_step_t       step;

    // input field decode
    assign in_kind    = s_tuser;
    assign in_row     = s_tdata[2:0];
    assign in_bits    = s_tdata[10:3];
    assign in_cnt     = s_tdata[14:11];
    assign in_cnt_sat = (in_cnt > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : in_cnt;
    assign in_xfer    = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);

    assign wr_a = in_xfer && (in_kind == KIND_LOAD_A);
    assign wr_b = in_xfer && (in_kind == KIND_LOAD_B);

    // row reads for the current ordering, b row chosen through the mapping
    assign rd_issue  = (state_reg == ST_CHECK) && (rd_idx_reg < count_a_reg);
    assign rd_addr_a = rd_idx_reg[IDX_W-1:0];
    assign rd_addr_b = perm_reg[rd_idx_reg[IDX_W-1:0]];

    gis_row_mem u_mem_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_a),
        .wr_addr (in_row),
        .wr_data (in_bits),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr_a),
        .rd_data (row_a)
    );

    gis_row_mem u_mem_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_b),
        .wr_addr (in_row),
        .wr_data (in_bits),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr_b),
        .rd_data (row_b)
    );

    gis_perm_step u_step (
        .count (count_a_reg),
        .perm  (perm_reg),
        .step  (step)
    );

    // one row compared in parallel over its columns
    always_comb begin
        row_ok = 1'b1;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if ((CNT_W'(j) < count_a_reg) && (row_a[j] != row_b[perm_reg[j]])) begin
                row_ok = 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_VERTICES; k++) begin
            perm_ident[k] = IDX_W'(k);
        end
    end

    assign last_idx = count_a_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        count_a_next     = count_a_reg;
        count_b_next     = count_b_reg;
        perm_next        = perm_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        emit_idx_next    = emit_idx_reg;
        emit_single_next = emit_single_reg;
        emit_found_next  = emit_found_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (wr_a) begin
                    count_a_next = in_cnt_sat;
                end
                if (wr_b) begin
                    count_b_next = in_cnt_sat;
                end
                if (in_xfer && (in_kind == KIND_RUN)) begin
                    if (count_a_reg != count_b_reg) begin
                        emit_single_next = 1'b1;
                        emit_found_next  = 1'b0;
                        state_next       = ST_EMIT;
                    end else if (count_a_reg == '0) begin
                        emit_single_next = 1'b1;
                        emit_found_next  = 1'b1;
                        state_next       = ST_EMIT;
                    end else begin
                        perm_next   = perm_ident;
                        rd_idx_next = '0;
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (cmp_valid_reg && !row_ok) begin
                    // mismatch: drop the read in flight and step the ordering
                    perm_next   = step.next;
                    rd_idx_next = '0;
                    if (step.wrap) begin
                        emit_single_next = 1'b1;
                        emit_found_next  = 1'b0;
                        state_next       = ST_EMIT;
                    end
                end else if (cmp_valid_reg && ({1'b0, cmp_idx_reg} == last_idx)) begin
                    emit_single_next = 1'b0;
                    emit_idx_next    = '0;
                    state_next       = ST_EMIT;
                end else begin
                    cmp_valid_next = rd_issue;
                    cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                    if (rd_issue) begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (emit_single_reg) begin
                        out_data_next = {1'b0, {IDX_W{1'b0}}, {IDX_W{1'b0}}, emit_found_reg};
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        out_data_next = {1'b0, perm_reg[emit_idx_reg], emit_idx_reg, 1'b1};
                        out_last_next = ({1'b0, emit_idx_reg} == last_idx);
                        if ({1'b0, emit_idx_reg} == last_idx) begin
                            state_next = ST_IDLE;
                        end else begin
                            emit_idx_next = emit_idx_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers and output payload
    always_ff @(posedge aclk) begin
        perm_reg        <= perm_next;
        rd_idx_reg      <= rd_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        emit_idx_reg    <= emit_idx_next;
        emit_single_reg <= emit_single_next;
        emit_found_reg  <= emit_found_next;
        out_data_reg    <= out_data_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/gis_checker.sv
module gis_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gis_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import gis_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a not-found result ends the run and carries no mapping
    a_notfound_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tlast && (m_tdata[OUT_DATA_W-1:1] == '0))
        else $error("not-found result malformed");

    // a run transfer closes the input until the run is done
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_RUN) |=> !s_tready)
        else $error("input open during a run");

    // pad bit above the image field stays clear on every result
    a_vertex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[OUT_DATA_W-1])
        else $error("pad bit set in result");

endmodule

bind graph_isomorphism_search_unit gis_checker u_gis_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/graph_isomorphism_search_unit_tb.sv
`timescale 1ns / 100ps

module graph_isomorphism_search_unit_tb;

    import gis_pkg::*;

    // kind value the block has no use for
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 200;
    localparam int GAP_MAX      = 13;
    localparam int DRAIN_CYCLES = 40;
    // one full 8-vertex miss is the longest case, everything else is far below
    localparam int CYCLE_LIMIT  = 4_000_000;

    // one command on the input stream
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] row;
        row_t       bits;
        logic [3:0] count;
    } graph_cmd_t;

    // one entry of the answer stream
    typedef struct packed {
        logic       found;
        logic [2:0] vertex;
        logic [2:0] image;
        logic       last;
    } map_entry_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // row_index[2:0], row_bits[10:3], vertex_count[14:11], zero pad [15]
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // kind[1:0]
    logic [1:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // found[0], vertex[3:1], image[6:4], zero pad [7]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    graph_isomorphism_search_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // shadow copy of the block state
    row_t       graph_a [MAX_VERTICES];
    row_t       graph_b [MAX_VERTICES];
    int         count_a = 0;
    int         count_b = 0;
    logic [2:0] order_map [MAX_VERTICES];

    graph_cmd_t graph_cmds [$];
    map_entry_t awaited_entries [$];
    int         stim_items  = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    initial begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            graph_a[i] = '0;
            graph_b[i] = '0;
        end
    end

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    function automatic void push_entry(input logic found, input int vertex, input int image,
                                       input logic last);
        map_entry_t e;
        e.found  = found;
        e.vertex = 3'(vertex);
        e.image  = 3'(image);
        e.last   = last;
        awaited_entries.push_back(e);
    endfunction

    // every edge of a matches the relabeled edge of b
    function automatic bit ordering_fits(input int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (graph_a[i][j] != graph_b[order_map[i]][order_map[j]]) return 1'b0;
        return 1'b1;
    endfunction

    // step to the next lexicographic ordering, 0 once all are used up
    function automatic bit next_ordering(input int n);
        int         i;
        int         j;
        int         lo;
        int         hi;
        logic [2:0] t;
        if (n < 2) return 1'b0;
        i = n - 2;
        while (i >= 0 && order_map[i] >= order_map[i+1]) i--;
        if (i < 0) return 1'b0;
        j = n - 1;
        while (order_map[j] <= order_map[i]) j--;
        t = order_map[i];
        order_map[i] = order_map[j];
        order_map[j] = t;
        lo = i + 1;
        hi = n - 1;
        while (lo < hi) begin
            t = order_map[lo];
            order_map[lo] = order_map[hi];
            order_map[hi] = t;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    // update the shadow state and queue the answers one command causes
    function automatic void apply_graph_cmd(input graph_cmd_t c);
        int n;
        int sat;
        bit hit;
        sat = (int'(c.count) > MAX_VERTICES) ? MAX_VERTICES : int'(c.count);
        case (c.kind)
            KIND_LOAD_A: begin
                graph_a[c.row] = c.bits;
                count_a = sat;
            end
            KIND_LOAD_B: begin
                graph_b[c.row] = c.bits;
                count_b = sat;
            end
            KIND_RUN: begin
                if (count_a != count_b) begin
                    push_entry(1'b0, 0, 0, 1'b1);
                end else if (count_a == 0) begin
                    push_entry(1'b1, 0, 0, 1'b1);
                end else begin
                    n = count_a;
                    for (int i = 0; i < n; i++) order_map[i] = 3'(i);
                    hit = ordering_fits(n);
                    while (!hit && next_ordering(n)) hit = ordering_fits(n);
                    if (hit) begin
                        for (int i = 0; i < n; i++)
                            push_entry(1'b1, i, order_map[i], i == n - 1);
                    end else begin
                        push_entry(1'b0, 0, 0, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic push_cmd(input logic [1:0] kind, input int row, input int bits,
                            input int count);
        graph_cmd_t c;
        c.kind  = kind;
        c.row   = row[2:0];
        c.bits  = bits[7:0];
        c.count = count[3:0];
        graph_cmds.push_back(c);
        if (kind != KIND_UNUSED) stim_items++;
    endtask

    // load both graphs completely, then search, mostly with b a relabeled a
    task automatic queue_search_case();
        int         n;
        int         pick;
        int         mode;
        int         cnt_field;
        int         i;
        int         j;
        int         k;
        logic [2:0] p [MAX_VERTICES];
        logic [2:0] t;
        row_t       ga [MAX_VERTICES];
        row_t       gb [MAX_VERTICES];
        pick = $urandom_range(0, 99);
        n = (pick < 8) ? 0 : (pick < 18) ? 1 : (pick < 35) ? 2 : (pick < 55) ? 3 :
            (pick < 72) ? 4 : (pick < 86) ? 5 : (pick < 94) ? 6 : (pick < 97) ? 7 : 8;
        for (i = 0; i < MAX_VERTICES; i++) begin
            ga[i] = row_t'($urandom_range(0, 255));
            gb[i] = row_t'($urandom_range(0, 255));
            p[i]  = 3'(i);
        end
        // big graphs only as cheap hits: identity or the second ordering
        if (n >= 7) begin
            mode = 0;
            if ($urandom_range(0, 1) == 1) begin
                t = p[n-2];
                p[n-2] = p[n-1];
                p[n-1] = t;
            end
        end else begin
            pick = $urandom_range(0, 9);
            mode = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
            for (i = n - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                t = p[i];
                p[i] = p[k];
                p[k] = t;
            end
        end
        if (mode != 2)
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++)
                    gb[p[i]][p[j]] = ga[i][j];
        // one flipped edge usually breaks the match
        if (mode == 1 && n > 0) begin
            i = $urandom_range(0, n - 1);
            j = $urandom_range(0, n - 1);
            gb[i][j] = ~gb[i][j];
        end
        cnt_field = (n == MAX_VERTICES) ? $urandom_range(MAX_VERTICES, 15) : n;
        if (n == 0) begin
            push_cmd(KIND_LOAD_A, $urandom_range(0, 7), ga[0], 0);
            push_cmd(KIND_LOAD_B, $urandom_range(0, 7), gb[0], 0);
        end else begin
            for (i = 0; i < n; i++) push_cmd(KIND_LOAD_A, i, ga[i], cnt_field);
            for (i = 0; i < n; i++) push_cmd(KIND_LOAD_B, i, gb[i], cnt_field);
        end
        push_cmd(KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 15));
        if ($urandom_range(0, 4) == 0)
            push_cmd(KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 255),
                     $urandom_range(0, 15));
    endtask

    task automatic queue_random_part();
        int pick;
        int ca;
        int cb;
        while (stim_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_search_case();
            end else if (pick < 82) begin
                // counts that differ after saturation
                ca = $urandom_range(0, 15);
                cb = $urandom_range(0, 15);
                while ((ca > MAX_VERTICES ? MAX_VERTICES : ca) ==
                       (cb > MAX_VERTICES ? MAX_VERTICES : cb))
                    cb = $urandom_range(0, 15);
                push_cmd(KIND_LOAD_A, $urandom_range(0, 7), $urandom_range(0, 255), ca);
                push_cmd(KIND_LOAD_B, $urandom_range(0, 7), $urandom_range(0, 255), cb);
                push_cmd(KIND_RUN, $urandom_range(0, 7), $urandom_range(0, 255),
                         $urandom_range(0, 15));
            end else if (pick < 90) begin
                push_cmd(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 255),
                         $urandom_range(0, 15));
            end else begin
                // stray load, the next case reloads what it needs
                push_cmd($urandom_range(0, 1) ? KIND_LOAD_B : KIND_LOAD_A,
                         $urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 15));
            end
        end
    endtask

    // driver: presents queued commands with random gaps
    graph_cmd_t cur_cmd   = '0;
    bit         cmd_held  = 1'b0;
    int         send_gap  = 0;
    int         send_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            cmd_held = 1'b0;
            send_gap = 0;
        end else begin
            // transfer taken, predict and draw the next gap
            if (s_tvalid && s_tready) begin
                apply_graph_cmd(cur_cmd);
                cmd_held = 1'b0;
                if (send_calm != 0) begin
                    send_calm--;
                    send_gap = 0;
                end else begin
                    send_gap = $urandom_range(0, GAP_MAX);
                    if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(8, 30);
                end
            end
            if (!cmd_held) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (graph_cmds.size() != 0) begin
                    cur_cmd  = graph_cmds.pop_front();
                    cmd_held = 1'b1;
                end
            end
            s_tvalid <= cmd_held;
            s_tdata  <= {1'b0, cur_cmd.count, cur_cmd.bits, cur_cmd.row};
            s_tuser  <= cur_cmd.kind;
        end
    end

    // monitor: random back-pressure, compare each answer with the oldest prediction
    int         recv_gap  = 0;
    int         recv_calm = 0;
    map_entry_t got;
    map_entry_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.found  = m_tdata[0];
                got.vertex = m_tdata[3:1];
                got.image  = m_tdata[6:4];
                got.last   = m_tlast;
                if (awaited_entries.size() == 0) begin
                    log_error($sformatf("unexpected result: found=%0d vertex=%0d image=%0d last=%0d",
                                        got.found, got.vertex, got.image, got.last));
                end else begin
                    want = awaited_entries.pop_front();
                    if (got.found !== want.found || got.vertex !== want.vertex ||
                        got.image !== want.image || got.last !== want.last)
                        log_error($sformatf({"mismatch: expected found=%0d vertex=%0d ",
                                             "image=%0d last=%0d, got found=%0d vertex=%0d ",
                                             "image=%0d last=%0d"},
                                            want.found, want.vertex, want.image, want.last,
                                            got.found, got.vertex, got.image, got.last));
                end
                if (recv_calm != 0) begin
                    recv_calm--;
                    recv_gap = 0;
                end else begin
                    recv_gap = $urandom_range(0, GAP_MAX);
                    if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(8, 30);
                end
            end else if (recv_gap != 0) begin
                recv_gap--;
            end
            m_tready <= (recv_gap == 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;

        // directed: empty graphs straight after reset
        push_cmd(KIND_RUN, 0, 0, 0);
        // unused kind with every field at its top
        push_cmd(KIND_UNUSED, 7, 255, 15);
        // unequal counts
        push_cmd(KIND_LOAD_A, 0, 8'h01, 1);
        push_cmd(KIND_RUN, 7, 255, 15);
        // single vertex, self loops agree
        push_cmd(KIND_LOAD_B, 0, 8'h01, 1);
        push_cmd(KIND_RUN, 0, 0, 0);
        // single vertex, self loops differ
        push_cmd(KIND_LOAD_B, 0, 8'h00, 1);
        push_cmd(KIND_RUN, 3, 8'hA5, 9);
        // eight vertices, count saturating, loop counts differ so every ordering fails
        push_cmd(KIND_LOAD_A, 7, 8'hFF, 15);
        push_cmd(KIND_LOAD_B, 7, 8'h80, 8);
        push_cmd(KIND_RUN, 7, 255, 15);
        // same graphs on both sides, identity hit
        push_cmd(KIND_LOAD_B, 0, 8'h01, 8);
        push_cmd(KIND_LOAD_B, 7, 8'hFF, 12);
        push_cmd(KIND_RUN, 0, 0, 0);
        // two vertices swapped, junk bits above the count
        push_cmd(KIND_LOAD_A, 0, 8'h01, 2);
        push_cmd(KIND_LOAD_A, 1, 8'hFC, 2);
        push_cmd(KIND_LOAD_B, 0, 8'hFC, 2);
        push_cmd(KIND_LOAD_B, 1, 8'h02, 2);
        push_cmd(KIND_RUN, 5, 8'h5A, 6);

        stim_items = 0;
        queue_random_part();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for all commands to go out and all answers to come back
        while (graph_cmds.size() != 0 || cmd_held || awaited_entries.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && awaited_entries.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
